/* design/egd_pkg.sv */
// Shared widths and types for the exp-Golomb code decoder.
`timescale 1ns / 1ps

package egd_pkg;

	localparam int WIN_W   = 64;  // bitstream window
	localparam int CODE_W  = 32;  // ue/se code width
	localparam int CNT_W   = 6;   // leading zero count, 0..32
	localparam int SHAMT_W = 6;   // field shift amount, 0..63
	localparam int CONS_W  = 7;   // bits consumed, 1..64
	localparam int MDATA_W = 72;  // output tdata, padded to whole bytes

	// Result of the leading zero scan.
	typedef struct packed {
		logic [CNT_W-1:0] zeros;   // zero run, clamped at the cap
		logic             capped;  // zero run reached the cap
	} lz_t;

endpackage

/* design/egd_lzc.sv */
// Leading zero counter over the top word of the window, clamped at the cap.
`timescale 1ns / 1ps

module egd_lzc #(
	parameter int MAX_LEADING_ZEROS = 32
) (
	input  logic [egd_pkg::CODE_W-1:0] word,
	output egd_pkg::lz_t               lz
);
	import egd_pkg::*;

	localparam logic [CNT_W-1:0] Cap = CNT_W'(MAX_LEADING_ZEROS);

	logic [CODE_W-1:0] x;
	logic [CNT_W-1:0]  cnt;

	// Binary search: five halving steps, then the all-zero case.
	always_comb begin
		x   = word;
		cnt = '0;
		if (x[31 -: 16] == '0) begin
			cnt = cnt + CNT_W'(16);
			x   = x << 16;
		end
		if (x[31 -: 8] == '0) begin
			cnt = cnt + CNT_W'(8);
			x   = x << 8;
		end
		if (x[31 -: 4] == '0) begin
			cnt = cnt + CNT_W'(4);
			x   = x << 4;
		end
		if (x[31 -: 2] == '0) begin
			cnt = cnt + CNT_W'(2);
			x   = x << 2;
		end
		if (x[31] == 1'b0) begin
			cnt = cnt + CNT_W'(1);
			x   = x << 1;
		end
		if (x[31] == 1'b0) begin
			cnt = cnt + CNT_W'(1);
		end
	end

	assign lz.capped = (cnt >= Cap);
	assign lz.zeros  = (cnt >= Cap) ? Cap : cnt;

endmodule

/* design/egd_field.sv */
// Field extraction and ue/se mapping from the window and its zero run.
`timescale 1ns / 1ps

module egd_field (
	input  logic [egd_pkg::WIN_W-1:0]  window,
	input  egd_pkg::lz_t               lz,
	output logic [egd_pkg::CODE_W-1:0] ue,
	output logic [egd_pkg::CODE_W-1:0] se,
	output logic [egd_pkg::CONS_W-1:0] consumed
);
	import egd_pkg::*;

	logic [CONS_W-1:0]  twice;
	logic [CONS_W-1:0]  shamt_full;
	logic [SHAMT_W-1:0] shamt;
	logic [WIN_W-1:0]   shifted;
	logic [CODE_W-1:0]  field;
	logic [CODE_W:0]    inc;
	logic [CODE_W-1:0]  mag;

	// Bits above the field are the zero run, so no mask is needed.
	assign twice      = {lz.zeros, 1'b0};
	assign shamt_full = CONS_W'(63) - twice + CONS_W'(lz.capped);
	assign shamt      = shamt_full[SHAMT_W-1:0];
	assign shifted    = window >> shamt;
	assign field      = shifted[CODE_W-1:0];

	assign consumed = twice + CONS_W'(1) - CONS_W'(lz.capped);

	// Floor at zero for an all-zero capped field.
	assign ue  = (field == '0) ? '0 : field - CODE_W'(1);
	assign inc = {1'b0, ue} + (CODE_W+1)'(1);
	assign mag = inc[CODE_W:1];
	assign se  = ue[0] ? mag : (CODE_W'(0) - mag);

endmodule

/* design/exp_golomb_code_decoder_unit.sv */
// Top level of the exp-Golomb ue(v)/se(v) code decoder.
`timescale 1ns / 1ps
//
//  channel  dir  tdata fields (low bit up)                         tuser
//  s_axis   in   bit_window[63:0]                                  -
//  m_axis   out  unsigned_code[31:0] signed_code[63:32]            -
//                bits_consumed[70:64], pad[71]
//
//  One item per cycle while m_axis is not stalled. Stage 1 holds the
//  window; the zero count, field shift and ue/se mapping run between
//  stage 1 and the result register (stage 2).
//  Reset clears both stage valid flags; payload registers are not reset.
//  A stalled result holds in stage 2 while stage 1 still takes one item;
//  ready falls only when both stages are full and the output is stalled.

module exp_golomb_code_decoder_unit #(
	parameter int MAX_LEADING_ZEROS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [egd_pkg::WIN_W-1:0]   s_tdata,   // bit_window
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [egd_pkg::MDATA_W-1:0] m_tdata    // unsigned_code, signed_code,
	                                               // bits_consumed, zero pad
);
	import egd_pkg::*;

	logic              valid_s1;
	logic [WIN_W-1:0]  window_s1;
	logic              valid_s2;
	logic [CODE_W-1:0] ue_s2;
	logic [CODE_W-1:0] se_s2;
	logic [CONS_W-1:0] cons_s2;

	logic              adv_s2;
	lz_t               lz;
	logic [CODE_W-1:0] ue;
	logic [CODE_W-1:0] se;
	logic [CONS_W-1:0] consumed;

	// Advance stage 2 when it is empty or its item is being taken.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			window_s1 <= s_tdata;
		end
	end

	// Count the zero run in the top word of the window.
	egd_lzc #(
		.MAX_LEADING_ZEROS(MAX_LEADING_ZEROS)
	) u_lzc (
		.word(window_s1[WIN_W-1 -: CODE_W]),
		.lz  (lz)
	);

	// Pull the field out and map it to ue/se.
	egd_field u_field (
		.window  (window_s1),
		.lz      (lz),
		.ue      (ue),
		.se      (se),
		.consumed(consumed)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			ue_s2   <= ue;
			se_s2   <= se;
			cons_s2 <= consumed;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, cons_s2, se_s2, ue_s2};

	// Both stages full with the output stalled: drop ready.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are full and stalled");

	// An accepted item lands in stage 1.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// Code length stays within one to twice the cap.
	a_cons_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cons_s2 != '0 &&
		              cons_s2 <= CONS_W'(2 * MAX_LEADING_ZEROS)))
		else $error("bits consumed out of range");

	// Odd codes map to positive, nonzero even codes to negative.
	a_se_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((ue_s2[0] && !se_s2[CODE_W-1]) ||
		              (!ue_s2[0] && ue_s2 != '0 && se_s2[CODE_W-1]) ||
		              (ue_s2 == '0 && se_s2 == '0)))
		else $error("signed code sign does not match unsigned code");

endmodule

/* tb/tb_exp_golomb_code_decoder_unit.sv */
// Self-checking testbench for the exp-Golomb ue(v)/se(v) code decoder.
`timescale 1ns / 1ps

localparam int ZERO_CAP = 32;   // leading zero cap the block is built with

// One decoded code as it leaves the block.
typedef struct packed {
	logic        [egd_pkg::CONS_W-1:0] nbits;   // bits consumed
	logic signed [egd_pkg::CODE_W-1:0] scode;   // se(v)
	logic        [egd_pkg::CODE_W-1:0] ucode;   // ue(v)
} golomb_code_t;

// Holds the codes still owed by the block, oldest first.
class golomb_scoreboard;
	golomb_code_t owed_codes[$];
	int           errors;

	function new();
		errors = 0;
	endfunction

	// Decode one window: count zeros up to the cap, cut the field, map to ue/se.
	static function golomb_code_t decode_window(logic [egd_pkg::WIN_W-1:0] win);
		golomb_code_t              r;
		int unsigned               z;
		logic [egd_pkg::WIN_W-1:0] field;
		logic [egd_pkg::CODE_W:0]  mag;
		z = 0;
		while (z < ZERO_CAP && !win[63 - z])
			z++;
		if (z < ZERO_CAP) begin
			// terminating one plus z suffix bits
			field   = (win >> (63 - 2 * z)) & ((64'd1 << (z + 1)) - 64'd1);
			r.nbits = 7'(2 * z + 1);
		end else begin
			// capped run: the next ZERO_CAP bits, whatever they hold
			field   = (win >> (64 - 2 * ZERO_CAP)) & ((64'd1 << ZERO_CAP) - 64'd1);
			r.nbits = 7'(2 * ZERO_CAP);
		end
		r.ucode = (field == '0) ? '0 : 32'(field - 64'd1);
		mag     = ({1'b0, r.ucode} + 33'd1) >> 1;
		r.scode = r.ucode[0] ? 32'(mag) : 32'(-mag);
		return r;
	endfunction

	function void note_window(logic [egd_pkg::WIN_W-1:0] win);
		owed_codes.push_back(decode_window(win));
	endfunction

	function void check_result(logic [egd_pkg::MDATA_W-1:0] tdata);
		golomb_code_t want;
		golomb_code_t got;
		got.ucode = tdata[31:0];
		got.scode = tdata[63:32];
		got.nbits = tdata[70:64];
		if (owed_codes.size() == 0) begin
			$display("%0t: result with none owed: ucode=%h scode=%h nbits=%0d",
			         $time, got.ucode, got.scode, got.nbits);
			errors++;
			return;
		end
		want = owed_codes.pop_front();
		if (got.ucode !== want.ucode) begin
			$display("%0t: ucode expected %h actual %h", $time, want.ucode, got.ucode);
			errors++;
		end
		if (got.scode !== want.scode) begin
			$display("%0t: scode expected %h actual %h", $time, want.scode, got.scode);
			errors++;
		end
		if (got.nbits !== want.nbits) begin
			$display("%0t: nbits expected %0d actual %0d", $time, want.nbits, got.nbits);
			errors++;
		end
	endfunction
endclass

module tb_exp_golomb_code_decoder_unit;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_TAIL    = 150;   // last items run without idling
	localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [egd_pkg::WIN_W-1:0]   s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [egd_pkg::MDATA_W-1:0] m_tdata;

	golomb_scoreboard sb;
	int               src_idle_pct;
	int               sink_idle_pct;
	int               quiet_cycles;

	exp_golomb_code_decoder_unit #(
		.MAX_LEADING_ZEROS(ZERO_CAP)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Note accepted windows, check accepted results, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_window(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("exp_golomb_code_decoder_unit test failed");
				$finish;
			end
		end
	end

	// Result side: hold ready low for bursts of random length, started per sink_idle_pct.
	initial begin : sink_stall
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(99) < sink_idle_pct)
					hold = $urandom_range(19, 1);
			end
		end
	end

	// Offer one window and hold it until the block takes it.
	task automatic send_window(input logic [egd_pkg::WIN_W-1:0] win);
		@(negedge clk);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(19, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= win;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Window with exactly z leading zeros (z below the cap) or a capped run.
	function automatic logic [egd_pkg::WIN_W-1:0] shaped_window(int unsigned z);
		logic [egd_pkg::WIN_W-1:0] win;
		win = {$urandom(), $urandom()};
		if (z < ZERO_CAP) begin
			if (z > 0)
				win = win & ~(~64'd0 << (64 - z));
			win[63 - z] = 1'b1;
		end else begin
			win[63:32] = '0;
		end
		return win;
	endfunction

	initial begin : stimulus
		logic [egd_pkg::WIN_W-1:0] corner_windows[$];
		sb            = new();
		quiet_cycles  = 0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		corner_windows = '{
			64'h0000_0000_0000_0000,  // capped run, field all zero: floor to 0
			64'h0000_0000_0000_0001,  // capped run, field one: ue 0
			64'h0000_0000_0000_0002,  // capped run, field two: ue 1
			64'h0000_0000_8000_0000,  // capped run, field top bit only
			64'h0000_0000_FFFF_FFFF,  // capped run, largest code
			64'h0000_0001_0000_0000,  // longest uncapped run, empty suffix
			64'h0000_0001_FFFF_FFFF,  // longest uncapped run, full suffix
			64'h0000_0002_0000_0000,
			64'h0000_FFFF_8000_0000,
			64'hFFFF_FFFF_FFFF_FFFF,  // single one bit: ue 0
			64'h8000_0000_0000_0000,
			64'h4000_0000_0000_0000,  // ue 1: se +1
			64'h6000_0000_0000_0000,  // ue 2: se -1
			64'h2000_0000_0000_0000,
			64'h3800_0000_0000_0000,
			64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA,
			64'h1234_5678_9ABC_DEF0
		};
		foreach (corner_windows[i])
			send_window(corner_windows[i]);

		// Random part: most windows shaped by zero run, the rest raw bits.
		// Idling levels change every hundred items; the tail runs flat out.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_TAIL) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else if (n % 100 == 0) begin
				case ($urandom_range(3))
					0: begin
						src_idle_pct  = 0;
						sink_idle_pct = 0;
					end
					1: begin
						src_idle_pct  = 15;
						sink_idle_pct = 0;
					end
					2: begin
						src_idle_pct  = 0;
						sink_idle_pct = 25;
					end
					default: begin
						src_idle_pct  = 30;
						sink_idle_pct = 30;
					end
				endcase
			end
			if ($urandom_range(99) < 70)
				send_window(shaped_window($urandom_range(ZERO_CAP)));
			else
				send_window({$urandom(), $urandom()});
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.owed_codes.size() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (5) @(posedge clk);

		if (sb.errors == 0 && sb.owed_codes.size() == 0)
			$display("exp_golomb_code_decoder_unit test passed");
		else
			$display("exp_golomb_code_decoder_unit test failed");
		$finish;
	end
endmodule

/* files.f */
design/egd_pkg.sv
design/egd_lzc.sv
design/egd_field.sv
design/exp_golomb_code_decoder_unit.sv
tb/tb_exp_golomb_code_decoder_unit.sv
